// File: hdl/drcu_pkg.sv
// ----------------------------------------------------------------------------
// DCQCN rate update package
// Shared widths, fixed-point constants, command and register codes and the
// per-flow context record.
// ----------------------------------------------------------------------------
package drcu_pkg;

  // fixed-point format of alpha and of the gain: 1.16, one integer bit kept
  localparam int unsigned FXP_FRAC = 16;
  localparam int unsigned ALPHA_W  = 17;
  localparam logic [ALPHA_W-1:0] ONE_FXP   = 17'h10000;
  localparam logic [ALPHA_W-1:0] ALPHA_MAX = 17'h1FFFF;

  localparam int unsigned FLOW_ID_W  = 6;
  localparam int unsigned FLOW_IDS   = 1 << FLOW_ID_W;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned BYTE_W     = 24;
  localparam int unsigned STAGE_W    = 8;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned LINE_W     = 20;
  localparam int unsigned RAI_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [STAGE_W-1:0] STAGE_MAX = 8'hFF;

  // register values after reset
  localparam logic [LINE_W-1:0]    LINE_RATE_RST   = 20'd12500;
  localparam logic [RAI_W-1:0]     RATE_INC_RST    = 16'd5;
  localparam logic [ALPHA_W-1:0]   ALPHA_GAIN_RST  = 17'd256;
  localparam logic [BYTE_W-1:0]    BYTE_THRESH_RST = 24'd10485760;
  localparam logic [TIME_W-1:0]    TIMER_PER_RST   = 32'd13750;
  localparam logic [STAGE_W-1:0]   FAST_STAGES_RST = 8'd5;

  typedef enum logic [1:0] {
    CMD_CNP   = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_TIMER = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_RATE   = 3'd0,
    CFG_RATE_INC    = 3'd1,
    CFG_ALPHA_GAIN  = 3'd2,
    CFG_BYTE_THRESH = 3'd3,
    CFG_TIMER_PER   = 3'd4,
    CFG_FAST_STAGES = 3'd5
  } cfg_idx_e;

  // per-flow context apart from the two rates
  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic [BYTE_W-1:0]  bytes;
    logic [STAGE_W-1:0] tstage;
    logic [STAGE_W-1:0] bstage;
    logic [TIME_W-1:0]  last;
  } ctx_t;

  localparam ctx_t CTX_RST = '{
    alpha:  ONE_FXP,
    bytes:  '0,
    tstage: '0,
    bstage: '0,
    last:   '0
  };

endpackage

// File: hdl/drcu_mul.sv
// ----------------------------------------------------------------------------
// DCQCN shared fixed-point multiplier
// Registered product of an operand and a 1.16 factor, shifted right by the
// fraction width (truncating). The result appears in the cycle after the operands.
// ----------------------------------------------------------------------------
module drcu_mul #(
  parameter int unsigned AW = 20
) (
  input  logic                                            clk_i,
  input  logic [AW-1:0]                                   a_i,
  input  logic [drcu_pkg::ALPHA_W-1:0]                    b_i,
  output logic [AW+drcu_pkg::ALPHA_W-drcu_pkg::FXP_FRAC-1:0] p_o
);

  localparam int unsigned FW = AW + drcu_pkg::ALPHA_W;
  localparam int unsigned PW = FW - drcu_pkg::FXP_FRAC;

  logic [FW-1:0] prod;
  logic [PW-1:0] p_q;

  assign prod = FW'(a_i) * FW'(b_i);

  always_ff @(posedge clk_i) begin
    p_q <= prod[FW-1:drcu_pkg::FXP_FRAC];
  end

  assign p_o = p_q;

endmodule

// File: hdl/dcqcn_rate_update.sv
// Results: each input is loaded, evaluated and written back before its result
//   enters the result register, which may wait for the previous result to be
//   taken; a new input is accepted only once the block is idle again.
// Reset: asynchronous, active low; afterwards a sweep fills every flow context,
//   and a line_rate write reloads the rates of all flows through a sweep.
// ----------------------------------------------------------------------------
// DCQCN rate update
// Per-flow DCQCN reaction point: CNP rate cut with alpha update, timer alpha decay,
// byte counter and timer driven recovery (fast recovery, then additive increase).
// ----------------------------------------------------------------------------
module dcqcn_rate_update #(
  parameter int unsigned NUM_FLOWS = 64,
  parameter int unsigned RATE_BITS = 20
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [drcu_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [drcu_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // event channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         cmd_i,
  input  logic [drcu_pkg::FLOW_ID_W-1:0]     flow_id_i,
  input  logic [drcu_pkg::LEN_W-1:0]         pkt_len_i,
  input  logic                               is_write_i,
  input  logic [drcu_pkg::TIME_W-1:0]        now_time_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [drcu_pkg::FLOW_ID_W-1:0]     out_flow_o,
  output logic [RATE_BITS-1:0]               new_rate_o,
  output logic                               send_ack_o,
  output logic                               rate_changed_o
);

  // --------------------------------------------------------------------------
  // Derived sizes
  // --------------------------------------------------------------------------
  localparam int unsigned FLOW_W = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1;
  // multiplier operand carries either a rate or an alpha
  localparam int unsigned MUL_AW = (RATE_BITS > drcu_pkg::ALPHA_W) ?
                                   RATE_BITS : drcu_pkg::ALPHA_W;
  localparam int unsigned MUL_PW = MUL_AW + drcu_pkg::ALPHA_W - drcu_pkg::FXP_FRAC;
  // target plus additive step, one bit of headroom for saturation
  localparam int unsigned INC_W  = ((RATE_BITS > drcu_pkg::RAI_W) ?
                                   RATE_BITS : drcu_pkg::RAI_W) + 1;
  localparam logic [RATE_BITS-1:0] RATE_MAX = '1;
  localparam logic [FLOW_W-1:0]    LAST_FLOW = FLOW_W'(NUM_FLOWS - 1);

  // one-hot sequencer
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SWEEP = 9'b000000010,
    S_LOAD  = 9'b000000100,
    S_EVAL  = 9'b000001000,
    S_CUT_A = 9'b000010000,
    S_CUT_B = 9'b000100000,
    S_DECAY = 9'b001000000,
    S_RECOV = 9'b010000000,
    S_WRITE = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [drcu_pkg::LINE_W-1:0]  line_rate_q;
  logic [drcu_pkg::RAI_W-1:0]   rate_inc_q;
  logic [drcu_pkg::ALPHA_W-1:0] alpha_gain_q;
  logic [drcu_pkg::BYTE_W-1:0]  byte_thresh_q;
  logic [drcu_pkg::TIME_W-1:0]  timer_per_q;
  logic [drcu_pkg::STAGE_W-1:0] fast_stages_q;
  logic                         line_wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_rate_q   <= drcu_pkg::LINE_RATE_RST;
      rate_inc_q    <= drcu_pkg::RATE_INC_RST;
      alpha_gain_q  <= drcu_pkg::ALPHA_GAIN_RST;
      byte_thresh_q <= drcu_pkg::BYTE_THRESH_RST;
      timer_per_q   <= drcu_pkg::TIMER_PER_RST;
      fast_stages_q <= drcu_pkg::FAST_STAGES_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        drcu_pkg::CFG_LINE_RATE:   line_rate_q   <= cfg_data_i[drcu_pkg::LINE_W-1:0];
        drcu_pkg::CFG_RATE_INC:    rate_inc_q    <= cfg_data_i[drcu_pkg::RAI_W-1:0];
        drcu_pkg::CFG_ALPHA_GAIN:  alpha_gain_q  <= cfg_data_i[drcu_pkg::ALPHA_W-1:0];
        drcu_pkg::CFG_BYTE_THRESH: byte_thresh_q <= cfg_data_i[drcu_pkg::BYTE_W-1:0];
        drcu_pkg::CFG_TIMER_PER:   timer_per_q   <= cfg_data_i[drcu_pkg::TIME_W-1:0];
        drcu_pkg::CFG_FAST_STAGES: fast_stages_q <= cfg_data_i[drcu_pkg::STAGE_W-1:0];
        default: ;
      endcase
    end
  end

  // a line_rate write reloads every flow's rates through a sweep
  assign line_wr = cfg_we_i && (cfg_idx_i == drcu_pkg::CFG_LINE_RATE);

  // gain clamped to one, and the decay factor (1 - g)
  logic [drcu_pkg::ALPHA_W-1:0] gain;
  logic [drcu_pkg::ALPHA_W-1:0] one_minus_g;

  assign gain        = (alpha_gain_q > drcu_pkg::ONE_FXP) ? drcu_pkg::ONE_FXP : alpha_gain_q;
  assign one_minus_g = drcu_pkg::ONE_FXP - gain;

  // --------------------------------------------------------------------------
  // Flow index: flow_id modulo NUM_FLOWS, folded into a constant table
  // --------------------------------------------------------------------------
  logic [FLOW_W-1:0] flow_map [drcu_pkg::FLOW_IDS];

  for (genvar i = 0; i < drcu_pkg::FLOW_IDS; i++) begin : g_map
    assign flow_map[i] = FLOW_W'(i % NUM_FLOWS);
  end

  // --------------------------------------------------------------------------
  // Input transaction capture
  // --------------------------------------------------------------------------
  logic                           in_acc;
  logic [1:0]                     cmd_q;
  logic [FLOW_W-1:0]              idx_q;
  logic [drcu_pkg::FLOW_ID_W-1:0] fid_q;
  logic [drcu_pkg::LEN_W-1:0]     len_q;
  logic                           wr_q;
  logic [drcu_pkg::TIME_W-1:0]    now_q;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= cmd_i;
      idx_q <= flow_map[flow_id_i];
      fid_q <= flow_id_i;
      len_q <= pkt_len_i;
      wr_q  <= is_write_i;
      now_q <= now_time_i;
    end
  end

  // --------------------------------------------------------------------------
  // Context memories: one write port, one registered read port each
  // --------------------------------------------------------------------------
  logic [RATE_BITS-1:0] cur_mem [NUM_FLOWS];
  logic [RATE_BITS-1:0] tgt_mem [NUM_FLOWS];
  drcu_pkg::ctx_t       ctx_mem [NUM_FLOWS];

  logic                 rate_we;
  logic                 ctx_we;
  logic [FLOW_W-1:0]    wr_addr;
  logic [RATE_BITS-1:0] cur_wdata;
  logic [RATE_BITS-1:0] tgt_wdata;
  drcu_pkg::ctx_t       ctx_wdata;
  logic [FLOW_W-1:0]    rd_addr;
  logic [RATE_BITS-1:0] cur_rd_q;
  logic [RATE_BITS-1:0] tgt_rd_q;
  drcu_pkg::ctx_t       ctx_rd_q;

  // read the addressed flow on every edge; only the acceptance edge matters
  assign rd_addr = flow_map[flow_id_i];

  always_ff @(posedge clk_i) begin
    if (rate_we) begin
      cur_mem[wr_addr] <= cur_wdata;
      tgt_mem[wr_addr] <= tgt_wdata;
    end
    cur_rd_q <= cur_mem[rd_addr];
    tgt_rd_q <= tgt_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ctx_we) begin
      ctx_mem[wr_addr] <= ctx_wdata;
    end
    ctx_rd_q <= ctx_mem[rd_addr];
  end

  // --------------------------------------------------------------------------
  // Shared multiplier
  // --------------------------------------------------------------------------
  logic [MUL_AW-1:0]            mul_a;
  logic [drcu_pkg::ALPHA_W-1:0] mul_b;
  logic [MUL_PW-1:0]            mul_p;

  drcu_mul #(
    .AW (MUL_AW)
  ) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // --------------------------------------------------------------------------
  // Working copy of the flow context
  // --------------------------------------------------------------------------
  logic [RATE_BITS-1:0]         cur_q, cur_d;
  logic [RATE_BITS-1:0]         tgt_q, tgt_d;
  drcu_pkg::ctx_t               ctx_q, ctx_d;
  logic                         ack_q, ack_d;
  logic                         chg_q, chg_d;

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    tgt_q <= tgt_d;
    ctx_q <= ctx_d;
    ack_q <= ack_d;
    chg_q <= chg_d;
  end

  // sweep control
  logic              sweep_all_q, sweep_all_d;
  logic [FLOW_W-1:0] sweep_idx_q, sweep_idx_d;

  // --------------------------------------------------------------------------
  // Event arithmetic around the working copy
  // --------------------------------------------------------------------------
  logic [drcu_pkg::BYTE_W:0]    byte_sum;
  logic                         byte_fire;
  logic [drcu_pkg::TIME_W-1:0]  elapsed;
  logic                         timer_fire;
  logic [drcu_pkg::STAGE_W-1:0] tstage_inc;
  logic [drcu_pkg::STAGE_W-1:0] bstage_inc;
  logic [drcu_pkg::ALPHA_W:0]   alpha_sum;
  logic                         fast;
  logic [INC_W-1:0]             tgt_inc;
  logic [RATE_BITS-1:0]         rt;
  logic [RATE_BITS:0]           avg_sum;

  assign byte_sum   = (drcu_pkg::BYTE_W+1)'(ctx_q.bytes) + (drcu_pkg::BYTE_W+1)'(len_q);
  assign byte_fire  = byte_sum >= (drcu_pkg::BYTE_W+1)'(byte_thresh_q);
  assign elapsed    = now_q - ctx_q.last;
  assign timer_fire = elapsed >= timer_per_q;
  assign tstage_inc = (ctx_q.tstage == drcu_pkg::STAGE_MAX) ? ctx_q.tstage
                                                             : ctx_q.tstage + 1'b1;
  assign bstage_inc = (ctx_q.bstage == drcu_pkg::STAGE_MAX) ? ctx_q.bstage
                                                             : ctx_q.bstage + 1'b1;

  // CNP alpha: fxp(alpha, 1 - g) + g, saturated to the alpha field
  assign alpha_sum  = (drcu_pkg::ALPHA_W+1)'(mul_p[drcu_pkg::ALPHA_W:0]) +
                      (drcu_pkg::ALPHA_W+1)'(gain);

  // recovery: fast while both stage counts are below the limit,
  // otherwise raise the target by the additive step first
  assign fast    = (ctx_q.tstage < fast_stages_q) && (ctx_q.bstage < fast_stages_q);
  assign tgt_inc = INC_W'(tgt_q) + INC_W'(rate_inc_q);
  assign rt      = fast ? tgt_q :
                   ((tgt_inc > INC_W'(RATE_MAX)) ? RATE_MAX : tgt_inc[RATE_BITS-1:0]);
  assign avg_sum = (RATE_BITS+1)'(cur_q) + (RATE_BITS+1)'(rt);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic out_load;
  logic out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    sweep_all_d = sweep_all_q;
    sweep_idx_d = sweep_idx_q;
    cur_d       = cur_q;
    tgt_d       = tgt_q;
    ctx_d       = ctx_q;
    ack_d       = ack_q;
    chg_d       = chg_q;
    rate_we     = 1'b0;
    ctx_we      = 1'b0;
    wr_addr     = idx_q;
    cur_wdata   = cur_q;
    tgt_wdata   = tgt_q;
    ctx_wdata   = ctx_q;
    mul_a       = MUL_AW'(ctx_q.alpha);
    mul_b       = one_minus_g;
    out_load    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_LOAD;
        end
      end

      S_SWEEP: begin
        // write one flow a cycle; the full context only after reset
        rate_we   = 1'b1;
        ctx_we    = sweep_all_q;
        wr_addr   = sweep_idx_q;
        cur_wdata = RATE_BITS'(line_rate_q);
        tgt_wdata = RATE_BITS'(line_rate_q);
        ctx_wdata = drcu_pkg::CTX_RST;
        if (sweep_idx_q == LAST_FLOW) begin
          sweep_all_d = 1'b0;
          state_d     = S_IDLE;
        end else begin
          sweep_idx_d = sweep_idx_q + 1'b1;
        end
      end

      S_LOAD: begin
        cur_d   = cur_rd_q;
        tgt_d   = tgt_rd_q;
        ctx_d   = ctx_rd_q;
        ack_d   = 1'b0;
        chg_d   = 1'b0;
        state_d = S_EVAL;
      end

      S_EVAL: begin
        case (cmd_q)
          drcu_pkg::CMD_CNP: begin
            // cut factor 1 - alpha/2 on the current rate
            mul_a        = MUL_AW'(cur_q);
            mul_b        = drcu_pkg::ONE_FXP -
                           drcu_pkg::ALPHA_W'(ctx_q.alpha[drcu_pkg::ALPHA_W-1:1]);
            tgt_d        = cur_q;
            ctx_d.bytes  = '0;
            ctx_d.tstage = '0;
            ctx_d.bstage = '0;
            ctx_d.last   = now_q;
            chg_d        = 1'b1;
            state_d      = S_CUT_A;
          end
          drcu_pkg::CMD_DATA: begin
            ack_d = wr_q;
            if (byte_fire) begin
              ctx_d.bytes  = '0;
              ctx_d.bstage = bstage_inc;
              chg_d        = 1'b1;
              state_d      = S_RECOV;
            end else begin
              ctx_d.bytes = byte_sum[drcu_pkg::BYTE_W-1:0];
              state_d     = S_WRITE;
            end
          end
          drcu_pkg::CMD_TIMER: begin
            // issue alpha * (1 - g) now; the product is ready in the decay state
            if (timer_fire) begin
              ctx_d.last   = now_q;
              ctx_d.tstage = tstage_inc;
              chg_d        = 1'b1;
              state_d      = S_DECAY;
            end else begin
              state_d = S_WRITE;
            end
          end
          default: begin
            state_d = S_WRITE;
          end
        endcase
      end

      S_CUT_A: begin
        // take the cut rate; issue alpha * (1 - g) on the old alpha
        cur_d   = mul_p[RATE_BITS-1:0];
        state_d = S_CUT_B;
      end

      S_CUT_B: begin
        ctx_d.alpha = (alpha_sum > (drcu_pkg::ALPHA_W+1)'(drcu_pkg::ALPHA_MAX)) ?
                      drcu_pkg::ALPHA_MAX : alpha_sum[drcu_pkg::ALPHA_W-1:0];
        state_d     = S_WRITE;
      end

      S_DECAY: begin
        ctx_d.alpha = mul_p[drcu_pkg::ALPHA_W-1:0];
        state_d     = S_RECOV;
      end

      S_RECOV: begin
        tgt_d   = rt;
        cur_d   = avg_sum[RATE_BITS:1];
        state_d = S_WRITE;
      end

      S_WRITE: begin
        // hold here until the output register is free
        rate_we = 1'b1;
        ctx_we  = 1'b1;
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // a new line rate restarts the rate sweep from the first flow
    if (line_wr) begin
      sweep_idx_d = '0;
      state_d     = S_SWEEP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      sweep_all_q <= 1'b1;
      sweep_idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_all_q <= sweep_all_d;
      sweep_idx_q <= sweep_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic [drcu_pkg::FLOW_ID_W-1:0] out_flow_q;
  logic [RATE_BITS-1:0]           out_rate_q;
  logic                           out_ack_q;
  logic                           out_chg_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_flow_q <= fid_q;
      out_rate_q <= cur_q;
      out_ack_q  <= ack_q;
      out_chg_q  <= chg_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_flow_o     = out_flow_q;
  assign new_rate_o     = out_rate_q;
  assign send_ack_o     = out_ack_q;
  assign rate_changed_o = out_chg_q;

endmodule
